>>> src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key-value cache
// Request and result items, request and status codes, and the structs that
// run along the cell chain.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int DefEntries = 64;
  localparam int CapW       = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_KEY   = 2'd1,
    ST_NO_VALUE = 2'd2,
    ST_NO_ENTRY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_UPDATE,
    CMD_INSERT
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [7:0]  key_len;
    logic [31:0] value_in;
    logic [15:0] value_len;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] value_out;
  } rsp_t;

  // partial search results handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        found;
    logic [31:0] found_value;
    logic        old_ok;
    logic [63:0] old_stamp;
    logic        free_ok;
  } carry_t;

  // write-back command broadcast to all cells
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] value;
    logic [63:0] stamp;
    logic        inv_en;
  } cmd_t;

endpackage

>>> src/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one cache entry
// Holds one entry, folds it into the search carry and registers the carry
// for the next cell; applies write-back commands aimed at its slot.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; #(
  parameter int Entries = DefEntries,
  parameter int Idx     = 0,
  localparam int IW     = $clog2(Entries),
  localparam int CW     = $clog2(Entries + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   key_i,
  input  logic [7:0]    key_len_i,
  input  carry_t        carry_i,
  input  logic [IW-1:0] found_idx_i,
  input  logic [IW-1:0] old_idx_i,
  input  logic [IW-1:0] free_idx_i,
  input  logic [CW-1:0] count_i,
  output carry_t        carry_o,
  output logic [IW-1:0] found_idx_o,
  output logic [IW-1:0] old_idx_o,
  output logic [IW-1:0] free_idx_o,
  output logic [CW-1:0] count_o,
  input  cmd_t          cmd_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [IW-1:0] inv_idx_i
);

  localparam logic [IW-1:0] MyIdx = IW'(Idx);

  logic        valid_q;
  logic [31:0] key_q;
  logic [7:0]  key_len_q;
  logic [31:0] value_q;
  logic [63:0] stamp_q;

  carry_t        carry_d, carry_q;
  logic [IW-1:0] found_idx_d, found_idx_q;
  logic [IW-1:0] old_idx_d, old_idx_q;
  logic [IW-1:0] free_idx_d, free_idx_q;
  logic [CW-1:0] count_d, count_q;

  always_comb begin
    carry_d     = carry_i;
    found_idx_d = found_idx_i;
    old_idx_d   = old_idx_i;
    free_idx_d  = free_idx_i;
    count_d     = count_i + CW'(valid_q);
    if (valid_q && key_q == key_i && key_len_q == key_len_i && !carry_i.found) begin
      carry_d.found       = 1'b1;
      carry_d.found_value = value_q;
      found_idx_d         = MyIdx;
    end
    if (valid_q && (!carry_i.old_ok || stamp_q < carry_i.old_stamp)) begin
      carry_d.old_ok    = 1'b1;
      carry_d.old_stamp = stamp_q;
      old_idx_d         = MyIdx;
    end
    if (!valid_q && !carry_i.free_ok) begin
      carry_d.free_ok = 1'b1;
      free_idx_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      carry_q       <= '0;
    end else begin
      carry_q <= carry_d;
      if (cmd_i.inv_en && inv_idx_i == MyIdx) begin
        valid_q <= 1'b0;
      end
      if (cmd_i.kind == CMD_INSERT && wr_idx_i == MyIdx) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q <= found_idx_d;
    old_idx_q   <= old_idx_d;
    free_idx_q  <= free_idx_d;
    count_q     <= count_d;
    if (cmd_i.kind != CMD_NONE && wr_idx_i == MyIdx) begin
      stamp_q <= cmd_i.stamp;
      if (cmd_i.kind != CMD_TOUCH) begin
        value_q <= cmd_i.value;
      end
      if (cmd_i.kind == CMD_INSERT) begin
        key_q     <= key_i;
        key_len_q <= key_len_i;
      end
    end
  end

  assign carry_o     = carry_q;
  assign found_idx_o = found_idx_q;
  assign old_idx_o   = old_idx_q;
  assign free_idx_o  = free_idx_q;
  assign count_o     = count_q;

endmodule

>>> src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store with LRU replacement
// Requests set, get, delete or find an entry; each gives exactly one result.
//
// Usage: present req_i and raise start_i; the item is taken at the edge where
// start_i is high and busy_o is low. busy_o stays high until the result is
// out. The result appears on rsp_o for one cycle with done_o high; there is
// no back-pressure on the result side.
// Timing: the search runs down a chain of ENTRIES cells, one cell per cycle;
// done_o rises when the search has passed the last cell, and a new item
// can be taken at the edge that ends the done_o cycle. The chain length sets
// how often items can be taken.
// capacity is written through cfg_we_i / cfg_wdata_i and resets to 64; the
// user must write it only while no item is in flight (not enforced).
// Reset empties the store and clears the use counter; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = DefEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  req_t            req_i,
  output logic            done_o,
  output rsp_t            rsp_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CapW) ? CW : CapW;
  localparam logic [XW-1:0] EntriesX = XW'(ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic            inject_q;
  logic [CapW-1:0] cap_q;
  logic [63:0]     use_cnt_q;
  cmd_t            cmd_q;
  logic [IW-1:0]   wr_idx_q, inv_idx_q;
  rsp_t            rsp_q;
  logic            done_q;

  carry_t        carry_w     [ENTRIES+1];
  logic [IW-1:0] found_idx_w [ENTRIES+1];
  logic [IW-1:0] old_idx_w   [ENTRIES+1];
  logic [IW-1:0] free_idx_w  [ENTRIES+1];
  logic [CW-1:0] count_w     [ENTRIES+1];

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  assign carry_w[0]     = carry_t'({inject_q, {($bits(carry_t) - 1){1'b0}}});
  assign found_idx_w[0] = '0;
  assign old_idx_w[0]   = '0;
  assign free_idx_w[0]  = '0;
  assign count_w[0]     = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .Entries (ENTRIES),
      .Idx     (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_i       (req_q.key),
      .key_len_i   (req_q.key_len),
      .carry_i     (carry_w[g]),
      .found_idx_i (found_idx_w[g]),
      .old_idx_i   (old_idx_w[g]),
      .free_idx_i  (free_idx_w[g]),
      .count_i     (count_w[g]),
      .carry_o     (carry_w[g+1]),
      .found_idx_o (found_idx_w[g+1]),
      .old_idx_o   (old_idx_w[g+1]),
      .free_idx_o  (free_idx_w[g+1]),
      .count_o     (count_w[g+1]),
      .cmd_i       (cmd_q),
      .wr_idx_i    (wr_idx_q),
      .inv_idx_i   (inv_idx_q)
    );
  end

  carry_t        fin;
  logic [XW-1:0] cap_x, cap_eff, occ_x;
  logic [63:0]   stamp_nx;
  cmd_t          cmd_d;
  logic [IW-1:0] wr_idx_d, inv_idx_d;
  rsp_t          rsp_d;
  logic          bump;

  assign fin      = carry_w[ENTRIES];
  assign cap_x    = XW'(cap_q);
  assign cap_eff  = (cap_x > EntriesX) ? EntriesX : cap_x;
  assign occ_x    = XW'(count_w[ENTRIES]);
  assign stamp_nx = use_cnt_q + 64'd1;

  always_comb begin
    cmd_d        = '0;
    cmd_d.kind   = CMD_NONE;
    cmd_d.value  = req_q.value_in;
    cmd_d.stamp  = stamp_nx;
    wr_idx_d     = found_idx_w[ENTRIES];
    inv_idx_d    = found_idx_w[ENTRIES];
    rsp_d        = '0;
    rsp_d.status = ST_OK;
    bump         = 1'b0;
    if (req_q.mode == MODE_SET) begin
      if (req_q.value_in == '0 || req_q.value_len == '0) begin
        rsp_d.status = ST_NO_VALUE;
      end else if (fin.found) begin
        rsp_d.hit  = 1'b1;
        cmd_d.kind = CMD_UPDATE;
        bump       = 1'b1;
      end else if (cap_eff == '0) begin
        rsp_d.status = ST_NO_ENTRY;
      end else begin
        cmd_d.kind = CMD_INSERT;
        bump       = 1'b1;
        if (occ_x >= cap_eff) begin
          cmd_d.inv_en = 1'b1;
          inv_idx_d    = old_idx_w[ENTRIES];
          if (fin.free_ok && free_idx_w[ENTRIES] < old_idx_w[ENTRIES]) begin
            wr_idx_d = free_idx_w[ENTRIES];
          end else begin
            wr_idx_d = old_idx_w[ENTRIES];
          end
        end else begin
          wr_idx_d = free_idx_w[ENTRIES];
        end
      end
    end else if (req_q.key_len == '0) begin
      rsp_d.status = ST_NO_KEY;
    end else if (fin.found) begin
      rsp_d.hit = 1'b1;
      if (req_q.mode == MODE_GET) begin
        rsp_d.value_out = fin.found_value;
        cmd_d.kind      = CMD_TOUCH;
        bump            = 1'b1;
      end else if (req_q.mode == MODE_DELETE) begin
        cmd_d.inv_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inject_q  <= 1'b0;
      cap_q     <= CapReset;
      use_cnt_q <= '0;
      cmd_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      inject_q <= accept;
      done_q   <= 1'b0;
      cmd_q    <= '0;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fin.active) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            cmd_q   <= cmd_d;
            if (bump) begin
              use_cnt_q <= stamp_nx;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_SCAN && fin.active) begin
      rsp_q     <= rsp_d;
      wr_idx_q  <= wr_idx_d;
      inv_idx_q <= inv_idx_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_SCAN))
    else $error("result without a finished search");

  a_value_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.hit |-> rsp_o.value_out == '0)
    else $error("value_out set on a miss");

  a_error_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> !rsp_o.hit)
    else $error("hit reported with an error status");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !done_o)
    else $error("accepted item did not start a search");

endmodule
